// File: rtl/tmsm_pkg.sv
// Shared types and constants for the truncated multi-limb signed multiplier.
package tmsm_pkg;

	localparam int LIMB_W         = 64;
	localparam int HALF_W         = LIMB_W / 2;
	localparam int LIMB_FIELDS    = 5;
	localparam int LIMB_COUNT_DEF = 5;

	typedef logic [LIMB_W-1:0] limb_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic issue;
		logic first;
	} dp_cmd_t;

	typedef struct packed {
		logic pipe_busy;
	} dp_sts_t;

endpackage

// File: rtl/truncated_multilimb_signed_multiply.sv
// Top level of the truncated multi-limb signed multiplier.
// The single shared 64x64 multiplier (four 32x32 products per cycle) forms one limb partial product a cycle;
// a new request is accepted only in idle, once the previous one has signalled done.
// done pulses for one cycle with the result; the receiver cannot stall it.
// Reset (arst_n low) returns the sequencer to idle and clears the pipeline valids.
module truncated_multilimb_signed_multiply import tmsm_pkg::*; #(
	parameter int LIMB_COUNT = LIMB_COUNT_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	output logic  done,
	input  limb_t a_limb0,
	input  limb_t a_limb1,
	input  limb_t a_limb2,
	input  limb_t a_limb3,
	input  limb_t a_limb4,
	input  logic  a_neg,
	input  limb_t b_limb0,
	input  limb_t b_limb1,
	input  limb_t b_limb2,
	input  limb_t b_limb3,
	input  limb_t b_limb4,
	input  logic  b_neg,
	output limb_t p_limb0,
	output limb_t p_limb1,
	output limb_t p_limb2,
	output limb_t p_limb3,
	output limb_t p_limb4,
	output logic  p_neg
);

	localparam int IDX_W = $clog2(LIMB_COUNT);

	dp_cmd_t          cmd;
	dp_sts_t          sts;
	logic [IDX_W-1:0] row_idx, col_idx;
	limb_t            a_in  [LIMB_FIELDS];
	limb_t            b_in  [LIMB_FIELDS];
	limb_t            p_out [LIMB_FIELDS];

	assign a_in = '{a_limb0, a_limb1, a_limb2, a_limb3, a_limb4};
	assign b_in = '{b_limb0, b_limb1, b_limb2, b_limb3, b_limb4};

	assign p_limb0 = p_out[0];
	assign p_limb1 = p_out[1];
	assign p_limb2 = p_out[2];
	assign p_limb3 = p_out[3];
	assign p_limb4 = p_out[4];

	tmsm_ctrl #(
		.LIMB_COUNT(LIMB_COUNT)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.sts     (sts),
		.cmd     (cmd),
		.row_idx (row_idx),
		.col_idx (col_idx),
		.busy    (busy),
		.done    (done)
	);

	tmsm_dp #(
		.LIMB_COUNT(LIMB_COUNT)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.row_idx (row_idx),
		.col_idx (col_idx),
		.a_in    (a_in),
		.a_neg   (a_neg),
		.b_in    (b_in),
		.b_neg   (b_neg),
		.sts     (sts),
		.p_out   (p_out),
		.p_neg   (p_neg)
	);

endmodule

// File: rtl/tmsm_ctrl.sv
// Sequencer that walks the partial-product schedule and frames each request.
module tmsm_ctrl import tmsm_pkg::*; #(
	parameter int LIMB_COUNT = LIMB_COUNT_DEF,
	localparam int IDX_W = $clog2(LIMB_COUNT)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  dp_sts_t          sts,
	output dp_cmd_t          cmd,
	output logic [IDX_W-1:0] row_idx,
	output logic [IDX_W-1:0] col_idx,
	output logic             busy,
	output logic             done
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIMB_COUNT - 1);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] i_q, j_q;
	logic             row_end;
	logic             last_issue;

	assign row_end    = ({1'b0, i_q} + {1'b0, j_q}) == {1'b0, LAST_IDX};
	assign last_issue = row_end && (i_q == LAST_IDX);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				if (last_issue) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd   = '0;
		busy  = 1'b1;
		done  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_ISSUE: begin
				cmd.issue = 1'b1;
				cmd.first = (j_q == '0);
			end
			ST_DRAIN: begin
			end
			ST_DONE: begin
				done = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign row_idx = i_q;
	assign col_idx = j_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				i_q <= '0;
				j_q <= '0;
			end else if (cmd.issue) begin
				if (row_end) begin
					i_q <= i_q + 1'b1;
					j_q <= '0;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/tmsm_dp.sv
// Operand store, split 64x64 multiplier pipeline and limb accumulator.
module tmsm_dp import tmsm_pkg::*; #(
	parameter int LIMB_COUNT = LIMB_COUNT_DEF,
	localparam int IDX_W = $clog2(LIMB_COUNT)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	input  logic [IDX_W-1:0] row_idx,
	input  logic [IDX_W-1:0] col_idx,
	input  limb_t            a_in [LIMB_FIELDS],
	input  logic             a_neg,
	input  limb_t            b_in [LIMB_FIELDS],
	input  logic             b_neg,
	output dp_sts_t          sts,
	output limb_t            p_out [LIMB_FIELDS],
	output logic             p_neg
);

	limb_t                a_q [LIMB_COUNT];
	limb_t                b_q [LIMB_COUNT];
	limb_t                p_q [LIMB_COUNT];
	limb_t                carry_q;
	logic                 neg_q;
	logic                 a_nz, b_nz;

	limb_t                a_sel, b_sel;
	logic [LIMB_W-1:0]    pp00_s1, pp01_s1, pp10_s1, pp11_s1;
	logic [IDX_W-1:0]     k_s1, k_s2;
	logic                 first_s1, first_s2;
	logic                 v_s1, v_s2;
	logic [2*LIMB_W-1:0]  prod_s2;
	limb_t                carry_in;
	logic [LIMB_W+1:0]    acc;

	always_comb begin
		a_nz = 1'b0;
		b_nz = 1'b0;
		for (int n = 0; n < LIMB_COUNT; n++) begin
			a_nz = a_nz | (|a_in[n]);
			b_nz = b_nz | (|b_in[n]);
		end
	end

	assign a_sel    = a_q[col_idx];
	assign b_sel    = b_q[row_idx];
	assign carry_in = first_s2 ? '0 : carry_q;
	assign acc      = (LIMB_W+2)'(prod_s2[LIMB_W-1:0]) + (LIMB_W+2)'(p_q[k_s2])
	                + (LIMB_W+2)'(carry_in);

	assign sts.pipe_busy = v_s1 | v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			pp00_s1  <= a_sel[HALF_W-1:0] * b_sel[HALF_W-1:0];
			pp01_s1  <= a_sel[HALF_W-1:0] * b_sel[LIMB_W-1:HALF_W];
			pp10_s1  <= a_sel[LIMB_W-1:HALF_W] * b_sel[HALF_W-1:0];
			pp11_s1  <= a_sel[LIMB_W-1:HALF_W] * b_sel[LIMB_W-1:HALF_W];
			k_s1     <= row_idx + col_idx;
			first_s1 <= cmd.first;
		end
		if (v_s1) begin
			prod_s2  <= {pp11_s1, pp00_s1}
			          + {HALF_W'(0), pp01_s1, HALF_W'(0)}
			          + {HALF_W'(0), pp10_s1, HALF_W'(0)};
			k_s2     <= k_s1;
			first_s2 <= first_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int n = 0; n < LIMB_COUNT; n++) begin
				a_q[n] <= a_in[n];
				b_q[n] <= b_in[n];
				p_q[n] <= '0;
			end
			neg_q <= (a_neg ^ b_neg) & a_nz & b_nz;
		end else if (v_s2) begin
			p_q[k_s2] <= acc[LIMB_W-1:0];
			carry_q   <= prod_s2[2*LIMB_W-1:LIMB_W] + LIMB_W'(acc[LIMB_W+1:LIMB_W]);
		end
	end

	for (genvar n = 0; n < LIMB_FIELDS; n++) begin : g_out
		if (n < LIMB_COUNT) begin : g_used
			assign p_out[n] = p_q[n];
		end else begin : g_unused
			assign p_out[n] = '0;
		end
	end

	assign p_neg = neg_q;

endmodule

// File: rtl/tmsm_checker.sv
// Port-level checker for the truncated multi-limb signed multiplier, with its bind.
module tmsm_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done without busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done longer than one cycle");

	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a request");

	a_accept_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted request did not hold busy");

endmodule

bind truncated_multilimb_signed_multiply tmsm_checker u_tmsm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

// File: sim/tb.sv
// Self-checking testbench for the truncated multi-limb signed multiplier: directed corners, then random requests under varied sender gaps.
module tb;
	import tmsm_pkg::*;

	localparam int N            = LIMB_COUNT_DEF;
	localparam int MAG_W        = LIMB_FIELDS * LIMB_W;
	localparam int DRAIN_CYCLES = N * (N + 1) / 2 + 8;
	localparam int STALL_LIMIT  = 5000;
	localparam int REPORT_MAX   = 10;

	typedef logic [MAG_W-1:0] magnitude_t;

	typedef struct packed {
		limb_t [LIMB_FIELDS-1:0] a;
		logic                    a_neg;
		limb_t [LIMB_FIELDS-1:0] b;
		logic                    b_neg;
	} operands_t;

	typedef struct packed {
		limb_t [LIMB_FIELDS-1:0] p;
		logic                    neg;
	} product_t;

	logic  clk;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	logic  busy;
	logic  done;
	limb_t a_limb0 = '0;
	limb_t a_limb1 = '0;
	limb_t a_limb2 = '0;
	limb_t a_limb3 = '0;
	limb_t a_limb4 = '0;
	logic  a_neg = 1'b0;
	limb_t b_limb0 = '0;
	limb_t b_limb1 = '0;
	limb_t b_limb2 = '0;
	limb_t b_limb3 = '0;
	limb_t b_limb4 = '0;
	logic  b_neg = 1'b0;
	limb_t p_limb0;
	limb_t p_limb1;
	limb_t p_limb2;
	limb_t p_limb3;
	limb_t p_limb4;
	logic  p_neg;

	product_t pending_products[$];
	int       mismatch_count = 0;
	int       quiet_cycles = 0;

	truncated_multilimb_signed_multiply #(
		.LIMB_COUNT(N)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.a_limb0(a_limb0),
		.a_limb1(a_limb1),
		.a_limb2(a_limb2),
		.a_limb3(a_limb3),
		.a_limb4(a_limb4),
		.a_neg  (a_neg),
		.b_limb0(b_limb0),
		.b_limb1(b_limb1),
		.b_limb2(b_limb2),
		.b_limb3(b_limb3),
		.b_limb4(b_limb4),
		.b_neg  (b_neg),
		.p_limb0(p_limb0),
		.p_limb1(p_limb1),
		.p_limb2(p_limb2),
		.p_limb3(p_limb3),
		.p_limb4(p_limb4),
		.p_neg  (p_neg)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic product_t predict_product(operands_t op);
		magnitude_t             used_mask;
		magnitude_t             am;
		magnitude_t             bm;
		logic [2*MAG_W-1:0]     full;
		product_t               r;
		used_mask = '0;
		for (int i = 0; i < N; i++)
			used_mask[i*LIMB_W +: LIMB_W] = '1;
		am = magnitude_t'(op.a) & used_mask;
		bm = magnitude_t'(op.b) & used_mask;
		full = am * bm;
		r.p = full[MAG_W-1:0] & used_mask;
		r.neg = (am != '0 && bm != '0) ? (op.a_neg ^ op.b_neg) : 1'b0;
		return r;
	endfunction

	function automatic operands_t make_operands(magnitude_t am, logic an, magnitude_t bm,
			logic bn);
		operands_t op;
		op.a = am;
		op.a_neg = an;
		op.b = bm;
		op.b_neg = bn;
		return op;
	endfunction

	function automatic magnitude_t random_magnitude();
		magnitude_t m;
		int         kind;
		limb_t      limb;
		m = '0;
		kind = $urandom_range(99);
		if (kind < 4)
			return m;
		for (int i = 0; i < LIMB_FIELDS; i++) begin
			if (kind < 60) begin
				limb = {$urandom, $urandom};
			end else begin
				case ($urandom_range(3))
					0: limb = '0;
					1: limb = '1;
					2: limb = {$urandom, $urandom} >> $urandom_range(LIMB_W - 1);
					default: limb = limb_t'(1) << $urandom_range(LIMB_W - 1);
				endcase
			end
			m[i*LIMB_W +: LIMB_W] = limb;
		end
		return m;
	endfunction

	task automatic note_mismatch(string field, logic [LIMB_W-1:0] exp_val,
			logic [LIMB_W-1:0] act_val);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("%0t mismatch on %s: expected %h, got %h", $realtime, field, exp_val,
				act_val);
	endtask

	task automatic send_request(operands_t op, int idle_pct);
		a_limb0 <= op.a[0];
		a_limb1 <= op.a[1];
		a_limb2 <= op.a[2];
		a_limb3 <= op.a[3];
		a_limb4 <= op.a[4];
		a_neg   <= op.a_neg;
		b_limb0 <= op.b[0];
		b_limb1 <= op.b[1];
		b_limb2 <= op.b[2];
		b_limb3 <= op.b[3];
		b_limb4 <= op.b[4];
		b_neg   <= op.b_neg;
		start   <= 1'b1;
		do @(posedge clk); while (busy);
		pending_products.push_back(predict_product(op));
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic run_random(int count, int idle_pct);
		for (int k = 0; k < count; k++)
			send_request(make_operands(random_magnitude(), 1'($urandom),
				random_magnitude(), 1'($urandom)), idle_pct);
	endtask

	task automatic test_corner_cases();
		magnitude_t ones;
		magnitude_t one;
		magnitude_t top;
		magnitude_t msb_limbs;
		ones = '1;
		one = magnitude_t'(1);
		top = magnitude_t'(1) << (MAG_W - 1);
		msb_limbs = {LIMB_FIELDS{64'h8000_0000_0000_0000}};
		// zero operands force a positive zero
		send_request(make_operands('0, 1'b1, '0, 1'b1), 0);
		send_request(make_operands('0, 1'b1, ones, 1'b0), 0);
		send_request(make_operands(ones, 1'b1, '0, 1'b1), 0);
		send_request(make_operands(magnitude_t'(0), 1'b0, top, 1'b1), 0);
		// all sign combinations
		send_request(make_operands(one, 1'b0, one, 1'b0), 0);
		send_request(make_operands(one, 1'b1, one, 1'b0), 0);
		send_request(make_operands(one, 1'b0, one, 1'b1), 0);
		send_request(make_operands(one, 1'b1, one, 1'b1), 0);
		// overflow and carry chains
		send_request(make_operands(ones, 1'b1, ones, 1'b0), 0);
		send_request(make_operands(ones, 1'b0, one, 1'b1), 0);
		send_request(make_operands(magnitude_t'(64'hFFFF_FFFF_FFFF_FFFF), 1'b0,
			magnitude_t'(64'hFFFF_FFFF_FFFF_FFFF), 1'b0), 0);
		send_request(make_operands(magnitude_t'(64'hFFFF_FFFF_FFFF_FFFF), 1'b1, ones, 1'b1), 0);
		send_request(make_operands(ones >> LIMB_W, 1'b0, magnitude_t'(64'hFFFF_FFFF_FFFF_FFFF),
			1'b1), 0);
		// truncated products: nonzero operands, some with all product limbs zero and the sign kept
		send_request(make_operands(top, 1'b1, magnitude_t'(2), 1'b0), 0);
		send_request(make_operands(one << (4 * LIMB_W), 1'b0, one << LIMB_W, 1'b1), 0);
		send_request(make_operands(one << (4 * LIMB_W), 1'b1, one, 1'b0), 0);
		send_request(make_operands(msb_limbs, 1'b0, msb_limbs, 1'b1), 0);
		send_request(make_operands({LIMB_FIELDS{64'h5555_5555_5555_5555}}, 1'b1,
			{LIMB_FIELDS{64'hAAAA_AAAA_AAAA_AAAA}}, 1'b1), 0);
		send_request(make_operands(top, 1'b0, top, 1'b0), 0);
	endtask

	task automatic test_back_to_back();
		run_random(500, 0);
	endtask

	task automatic test_sparse_requests();
		run_random(500, 81);
	endtask

	task automatic test_light_gaps();
		run_random(500, 16);
	endtask

	always @(posedge clk) begin
		product_t expd;
		product_t got;
		if (arst_n && done) begin
			got.p = {p_limb4, p_limb3, p_limb2, p_limb1, p_limb0};
			got.neg = p_neg;
			if (pending_products.size() == 0) begin
				note_mismatch("unexpected product", '0, got.p[0]);
			end else begin
				expd = pending_products.pop_front();
				for (int i = 0; i < LIMB_FIELDS; i++)
					if (got.p[i] !== expd.p[i])
						note_mismatch($sformatf("p_limb%0d", i), expd.p[i], got.p[i]);
				if (got.neg !== expd.neg)
					note_mismatch("p_neg", LIMB_W'(expd.neg), LIMB_W'(got.neg));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_cases();
		test_back_to_back();
		test_sparse_requests();
		test_light_gaps();
		start <= 1'b0;
		while (pending_products.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatch_count += pending_products.size();
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
